### design/crc8fb_pkg.sv
// Shared constants, types and functions of the CRC-8 frame builder.
package crc8fb_pkg;

  // Width of the frame number as printed; the port itself is 16 bits wide.
  localparam int NumberWidth = 16;
  localparam int NumW = (NumberWidth < 16) ? NumberWidth : 16;
  // The digit register also holds the 8-bit CRC.
  localparam int ValW = (NumW > 8) ? NumW : 8;
  // Room for up to nine times the largest power of ten.
  localparam int CmpW = ValW + 4;

  // Number of decimal digits of the largest value of a w-bit number.
  function automatic int count_digits(int w);
    longint lim;
    longint p;
    int n;
    lim = (longint'(1) << w) - 1;
    p = 10;
    n = 1;
    for (int k = 0; k < 12; k++) begin
      if (lim >= p) begin
        n++;
      end
      p = p * 10;
    end
    return n;
  endfunction

  localparam int NumDigits = count_digits(NumW);
  localparam int MaxDigits = (NumDigits > 3) ? NumDigits : 3;
  localparam int PosW = $clog2(MaxDigits);

  // Threshold m * 10^k used when a digit is taken off the top of a value.
  function automatic longint digit_thr(int m, int k);
    longint p;
    p = m;
    for (int i = 0; i < 12; i++) begin
      if (i < k) begin
        p = p * 10;
      end
    end
    return p;
  endfunction

  localparam logic [7:0] ChNul  = 8'h00;
  localparam logic [7:0] ChSoh  = 8'h01;
  localparam logic [7:0] ChStx  = 8'h02;
  localparam logic [7:0] ChEtx  = 8'h03;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] PolyLow = 8'h31;

  // One byte through the CRC-8, MSB first, no reflection.
  function automatic logic [7:0] crc_byte(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ PolyLow;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  localparam logic [7:0] CrcAfterSoh = crc_byte(8'h00, ChSoh);

  localparam int QueueDepth = 2;
  localparam int QPtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW = $clog2(QueueDepth + 1);

  // One classified message byte as it waits between front and back.
  typedef struct packed {
    logic            first;
    logic            last;
    logic [NumW-1:0] number;
    logic [7:0]      data;
  } cmd_t;

  typedef struct packed {
    logic             full;
    logic             empty;
    logic [QCntW-1:0] count;
  } q_status_t;

  typedef enum logic [2:0] {
    PhBegin,
    PhNum,
    PhStx,
    PhData,
    PhEtx,
    PhCrc,
    PhNul
  } phase_e;

endpackage

### design/crc8_frame_builder.sv
// Top level of the CRC-8 frame builder: front, command queue and back.
//
// The block wraps message bytes into frames. On the first byte of a frame
// it sends SOH, the frame number in decimal ASCII without leading zeros, and
// STX before the byte; later bytes pass through unchanged; after the byte
// marked last it sends ETX, the CRC-8 (polynomial 0x31, initial value zero,
// no reflection) in one to three decimal ASCII digits, and a NUL, which
// carries frame_end. The CRC covers SOH through the last message byte. The
// back end sends one output byte per cycle while a command waits and the
// sink takes bytes. A middle byte of a frame goes out alone; a first byte
// comes after SOH, the digits of its number and STX; and a last byte is
// followed by ETX, the CRC digits and NUL. A two-entry command queue lets
// the input keep taking bytes while the output sequencer is busy with a
// header or a trailer, and the output register holds a byte until its
// transfer without stopping the input side. After reset the block waits
// for the first byte of a frame.

module crc8_frame_builder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] frame_number_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        run_end_o,
  output logic        frame_end_o
);

  crc8fb_pkg::cmd_t      push_cmd;
  crc8fb_pkg::cmd_t      head_cmd;
  crc8fb_pkg::q_status_t q_status;
  logic                  push;
  logic                  pop;

  // The front classifies each byte: it is the first of a frame unless the
  // previous transfer was a byte without the last flag.
  crc8fb_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .frame_number_i (frame_number_i),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .q_status_i     (q_status),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  crc8fb_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (push_cmd),
    .pop_i    (pop),
    .head_o   (head_cmd),
    .status_o (q_status)
  );

  // The back walks through the header, the byte and the trailer of the
  // command at the head of the queue and releases it with its final byte.
  crc8fb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_cmd),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .run_end_o   (run_end_o),
    .frame_end_o (frame_end_o)
  );

  // A frame always ends on a NUL that also closes the run of its item.
  a_frame_end_nul : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> run_end_o && (out_byte_o == crc8fb_pkg::ChNul))
    else $error("frame_end without run_end on a NUL byte");

  // The queue never holds more commands than it has entries.
  a_queue_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.count <= crc8fb_pkg::QCntW'(crc8fb_pkg::QueueDepth))
    else $error("command queue overfilled");

  // A transfer with the last flag makes the next input byte the first of a frame.
  a_last_opens_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_byte_i |=> push_cmd.first)
    else $error("frame not reopened after last byte");

  // The back releases a command only while it sends a byte that ends a run.
  a_pop_on_run_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> out_valid_o && run_end_o)
    else $error("command released without a run end");

endmodule

### design/crc8fb_front.sv
// Input side: accepts message bytes and marks the first byte of each frame.
module crc8fb_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [15:0]            frame_number_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   last_byte_i,
  input  crc8fb_pkg::q_status_t  q_status_i,
  output logic                   push_o,
  output crc8fb_pkg::cmd_t       cmd_o
);

  logic inside_q, inside_d;
  logic accept;

  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept;

  always_comb begin
    cmd_o.first  = !inside_q;
    cmd_o.last   = last_byte_i;
    cmd_o.number = frame_number_i[crc8fb_pkg::NumW-1:0];
    cmd_o.data   = data_byte_i;
    inside_d     = inside_q;
    if (accept) begin
      inside_d = !last_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
    end else begin
      inside_q <= inside_d;
    end
  end

endmodule

### design/crc8fb_fifo.sv
// Short command queue between the front and the back of the frame builder.
module crc8fb_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  crc8fb_pkg::cmd_t      cmd_i,
  input  logic                  pop_i,
  output crc8fb_pkg::cmd_t      head_o,
  output crc8fb_pkg::q_status_t status_o
);

  localparam logic [crc8fb_pkg::QPtrW-1:0] LastPtr =
    crc8fb_pkg::QPtrW'(crc8fb_pkg::QueueDepth - 1);

  crc8fb_pkg::cmd_t mem_q [crc8fb_pkg::QueueDepth];
  logic [crc8fb_pkg::QPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [crc8fb_pkg::QCntW-1:0] count_q, count_d;
  logic do_push, do_pop;

  assign status_o.full  = (count_q == crc8fb_pkg::QCntW'(crc8fb_pkg::QueueDepth));
  assign status_o.empty = (count_q == '0);
  assign status_o.count = count_q;
  assign head_o         = mem_q[rd_ptr_q];

  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

### design/crc8fb_back.sv
// Output side: sequences header, message and trailer bytes and keeps the CRC.
module crc8fb_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  crc8fb_pkg::cmd_t      head_i,
  input  crc8fb_pkg::q_status_t q_status_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            out_byte_o,
  output logic                  run_end_o,
  output logic                  frame_end_o
);

  localparam int ValW = crc8fb_pkg::ValW;
  localparam int CmpW = crc8fb_pkg::CmpW;
  localparam int MaxDigits = crc8fb_pkg::MaxDigits;
  localparam int PosW = crc8fb_pkg::PosW;

  crc8fb_pkg::phase_e phase_q, phase_d;
  logic [7:0]      crc_q, crc_d;
  logic [ValW-1:0] val_q, val_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_byte_q, out_byte_d;
  logic            run_end_q, run_end_d;
  logic            frame_end_q, frame_end_d;

  logic [CmpW-1:0] thr [MaxDigits][9];
  logic [3:0]      dig;
  logic [ValW-1:0] rem;
  logic [7:0]      dig_char;
  logic [ValW-1:0] start_src;
  logic [PosW-1:0] start_pos;
  logic [7:0]      crc_in;
  logic [7:0]      crc_next;
  logic            adv, go, do_data;

  for (genvar k = 0; k < MaxDigits; k++) begin : g_pow
    for (genvar m = 1; m <= 9; m++) begin : g_mul
      assign thr[k][m-1] = CmpW'(crc8fb_pkg::digit_thr(m, k));
    end
  end

  // Top digit of the value at the current position and what is left below it.
  always_comb begin
    dig = '0;
    rem = val_q;
    for (int m = 1; m <= 9; m++) begin
      if ({4'b0000, val_q} >= thr[pos_q][m-1]) begin
        dig = 4'(m);
        rem = ValW'({4'b0000, val_q} - thr[pos_q][m-1]);
      end
    end
    dig_char = crc8fb_pkg::ChZero | {4'b0000, dig};
  end

  // Position of the leading digit, so that no leading zeros are printed.
  always_comb begin
    start_src = (phase_q == crc8fb_pkg::PhBegin) ? ValW'(head_i.number) : ValW'(crc_q);
    start_pos = '0;
    for (int k = 1; k < MaxDigits; k++) begin
      if ({4'b0000, start_src} >= thr[k][0]) begin
        start_pos = PosW'(k);
      end
    end
  end

  assign adv = !out_valid_q || out_ready_i;
  assign go  = adv && !q_status_i.empty;

  always_comb begin
    phase_d     = phase_q;
    crc_d       = crc_q;
    val_d       = val_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    run_end_d   = run_end_q;
    frame_end_d = frame_end_q;
    pop_o       = 1'b0;
    do_data     = 1'b0;
    crc_in      = head_i.data;
    case (phase_q)
      crc8fb_pkg::PhNum: crc_in = dig_char;
      crc8fb_pkg::PhStx: crc_in = crc8fb_pkg::ChStx;
      default:           crc_in = head_i.data;
    endcase
    crc_next = crc8fb_pkg::crc_byte(crc_q, crc_in);
    if (go) begin
      out_valid_d = 1'b1;
      run_end_d   = 1'b0;
      frame_end_d = 1'b0;
      case (phase_q)
        crc8fb_pkg::PhBegin: begin
          if (head_i.first) begin
            out_byte_d = crc8fb_pkg::ChSoh;
            crc_d      = crc8fb_pkg::CrcAfterSoh;
            val_d      = ValW'(head_i.number);
            pos_d      = start_pos;
            phase_d    = crc8fb_pkg::PhNum;
          end else begin
            do_data = 1'b1;
          end
        end
        crc8fb_pkg::PhNum: begin
          out_byte_d = dig_char;
          crc_d      = crc_next;
          val_d      = rem;
          if (pos_q == '0) begin
            phase_d = crc8fb_pkg::PhStx;
          end else begin
            pos_d = pos_q - 1'b1;
          end
        end
        crc8fb_pkg::PhStx: begin
          out_byte_d = crc8fb_pkg::ChStx;
          crc_d      = crc_next;
          phase_d    = crc8fb_pkg::PhData;
        end
        crc8fb_pkg::PhData: begin
          do_data = 1'b1;
        end
        crc8fb_pkg::PhEtx: begin
          out_byte_d = crc8fb_pkg::ChEtx;
          val_d      = ValW'(crc_q);
          pos_d      = start_pos;
          phase_d    = crc8fb_pkg::PhCrc;
        end
        crc8fb_pkg::PhCrc: begin
          out_byte_d = dig_char;
          val_d      = rem;
          if (pos_q == '0) begin
            phase_d = crc8fb_pkg::PhNul;
          end else begin
            pos_d = pos_q - 1'b1;
          end
        end
        crc8fb_pkg::PhNul: begin
          out_byte_d  = crc8fb_pkg::ChNul;
          run_end_d   = 1'b1;
          frame_end_d = 1'b1;
          crc_d       = '0;
          pop_o       = 1'b1;
          phase_d     = crc8fb_pkg::PhBegin;
        end
        default: begin
          phase_d = crc8fb_pkg::PhBegin;
        end
      endcase
      if (do_data) begin
        out_byte_d = head_i.data;
        crc_d      = crc_next;
        if (head_i.last) begin
          phase_d = crc8fb_pkg::PhEtx;
        end else begin
          run_end_d = 1'b1;
          pop_o     = 1'b1;
          phase_d   = crc8fb_pkg::PhBegin;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= crc8fb_pkg::PhBegin;
      out_valid_q <= 1'b0;
      crc_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      crc_q       <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q       <= val_d;
    pos_q       <= pos_d;
    out_byte_q  <= out_byte_d;
    run_end_q   <= run_end_d;
    frame_end_q <= frame_end_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_end_o   = run_end_q;
  assign frame_end_o = frame_end_q;

endmodule

### dv/tb_crc8_frame_builder.sv
// Self-checking testbench for the CRC-8 frame builder: directed table, random frames, scoreboard.
module tb_crc8_frame_builder;
  timeunit 1ns;
  timeprecision 1ps;

  // Random frames stop being started once this many message bytes have gone in.
  localparam int RandomItems = 210;
  // The run is abandoned after this many clock cycles, which leaves a wide
  // margin over the slowest correct run.
  localparam int CycleLimit = 200000;
  // Cycles watched after the last expected byte, to catch stray output.
  localparam int DrainCycles = 24;
  // Share of cycles, in per cent, on which either side holds back.
  localparam int IdlePercent = 27;
  // Only the low bits of the frame number are printed and folded into the CRC.
  localparam logic [31:0] NumberMask = (32'd1 << crc8fb_pkg::NumW) - 32'd1;

  // One byte of the framed output stream, as it is expected at the output.
  typedef struct {
    logic [7:0] octet;
    logic       run_end;
    logic       frame_end;
  } frame_byte_t;

  // One row of the directed table. Where n_known is not zero, the output
  // bytes are typed in and the top octet of known is the first of them;
  // otherwise the byte stream comes from the frame predictor.
  typedef struct packed {
    logic [15:0] number;
    logic [7:0]  data;
    logic        last;
    logic [3:0]  n_known;
    logic [63:0] known;
  } dir_row_t;

  localparam int NumDirRows = 21;
  localparam dir_row_t DirRows [NumDirRows] = '{
    // Frame zero straight after reset: SOH, a single '0', STX, then the byte.
    '{16'd0,     8'h00, 1'b0, 4'd4, 64'h01_30_02_00_00_00_00_00},
    // A middle byte passes straight through; its frame number is ignored.
    '{16'hFFFF,  8'hFF, 1'b0, 4'd1, 64'hFF_00_00_00_00_00_00_00},
    '{16'd0,     8'h01, 1'b1, 4'd0, 64'h0},
    // A one-byte frame with the largest number: header and trailer together.
    '{16'd65535, 8'h02, 1'b1, 4'd0, 64'h0},
    // The largest number printed in full, five digits.
    '{16'd65535, 8'h03, 1'b0, 4'd8, 64'h01_36_35_35_33_35_02_03},
    '{16'd0,     8'h00, 1'b0, 4'd1, 64'h00_00_00_00_00_00_00_00},
    '{16'd1234,  8'h80, 1'b1, 4'd0, 64'h0},
    '{16'd9,     8'hA5, 1'b1, 4'd0, 64'h0},
    '{16'd10,    8'h5A, 1'b0, 4'd5, 64'h01_31_30_02_5A_00_00_00},
    // The control characters are ordinary data inside a frame.
    '{16'd0,     8'h7F, 1'b0, 4'd1, 64'h7F_00_00_00_00_00_00_00},
    '{16'd0,     8'h80, 1'b0, 4'd1, 64'h80_00_00_00_00_00_00_00},
    '{16'd0,     8'h01, 1'b0, 4'd1, 64'h01_00_00_00_00_00_00_00},
    '{16'd0,     8'h02, 1'b0, 4'd1, 64'h02_00_00_00_00_00_00_00},
    '{16'd0,     8'h03, 1'b1, 4'd0, 64'h0},
    '{16'd12345, 8'h55, 1'b0, 4'd8, 64'h01_31_32_33_34_35_02_55},
    '{16'd0,     8'hAA, 1'b1, 4'd0, 64'h0},
    '{16'd32768, 8'h30, 1'b1, 4'd0, 64'h0},
    '{16'd1,     8'hFF, 1'b1, 4'd0, 64'h0},
    '{16'd100,   8'h00, 1'b1, 4'd0, 64'h0},
    '{16'd99,    8'h5A, 1'b0, 4'd5, 64'h01_39_39_02_5A_00_00_00},
    '{16'h5555,  8'hC3, 1'b1, 4'd0, 64'h0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] frame_number_i = '0;
  logic [7:0]  data_byte_i = '0;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        run_end_o;
  logic        frame_end_o;

  // Predictor state: the running CRC and whether a header has gone out.
  logic [7:0]  pred_crc = 8'h00;
  logic        pred_in_frame = 1'b0;

  // The bytes that one input transfer causes, and all bytes still owed.
  frame_byte_t item_run [$];
  frame_byte_t pending_bytes [$];
  frame_byte_t head_byte;

  int          err_count = 0;
  int          cycle_count = 0;
  // While set, neither side holds back, giving a stretch at full rate.
  logic        steady = 1'b0;

  crc8_frame_builder u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .frame_number_i (frame_number_i),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .run_end_o      (run_end_o),
    .frame_end_o    (frame_end_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // CRC-8 over one byte, one message bit at a time from the MSB. The feedback
  // bit is the top of the register xored with the incoming bit.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] acc;
    logic       fb;
    acc = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = acc[7] ^ b[i];
      acc = {acc[6:0], 1'b0} ^ (fb ? crc8fb_pkg::PolyLow : 8'h00);
    end
    return acc;
  endfunction

  function automatic void push_byte(input logic [7:0] octet, input logic frame_end);
    frame_byte_t fb;
    fb.octet = octet;
    fb.run_end = 1'b0;
    fb.frame_end = frame_end;
    item_run.push_back(fb);
  endfunction

  // Decimal ASCII, most significant digit first, with no leading zeros. The
  // digits of the frame number go into the CRC; those of the CRC itself do not.
  function automatic void push_decimal(input logic [31:0] value, input logic fold_in);
    logic [7:0]  digits [$];
    logic [31:0] rest;
    rest = value;
    do begin
      digits.push_front(8'(crc8fb_pkg::ChZero + rest % 10));
      rest = rest / 10;
    end while (rest != 0);
    foreach (digits[i]) begin
      if (fold_in) begin
        pred_crc = crc8_update(pred_crc, digits[i]);
      end
      push_byte(digits[i], 1'b0);
    end
  endfunction

  // Works out the output bytes of one message byte into item_run and moves
  // the frame state on.
  function automatic void predict_frame_bytes(input logic [15:0] number, input logic [7:0] data,
                                              input logic last);
    item_run.delete();
    if (!pred_in_frame) begin
      pred_crc = crc8_update(8'h00, crc8fb_pkg::ChSoh);
      push_byte(crc8fb_pkg::ChSoh, 1'b0);
      push_decimal(32'(number) & NumberMask, 1'b1);
      pred_crc = crc8_update(pred_crc, crc8fb_pkg::ChStx);
      push_byte(crc8fb_pkg::ChStx, 1'b0);
      pred_in_frame = 1'b1;
    end
    pred_crc = crc8_update(pred_crc, data);
    push_byte(data, 1'b0);
    if (last) begin
      push_byte(crc8fb_pkg::ChEtx, 1'b0);
      push_decimal(32'(pred_crc), 1'b0);
      push_byte(crc8fb_pkg::ChNul, 1'b1);
      pred_crc = 8'h00;
      pred_in_frame = 1'b0;
    end
    item_run[item_run.size() - 1].run_end = 1'b1;
  endfunction

  // Offers one message byte, waits for its transfer and books what it owes.
  // Valid is only lowered for an idle cycle, never between two back-to-back
  // items, so the signal sees one assignment per edge.
  task automatic send_message_byte(input logic [15:0] number, input logic [7:0] data,
                                   input logic last, input logic [3:0] n_known,
                                   input logic [63:0] known);
    frame_byte_t fb;
    while (!steady && $urandom_range(0, 99) < IdlePercent) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    frame_number_i <= number;
    data_byte_i    <= data;
    last_byte_i    <= last;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    predict_frame_bytes(number, data, last);
    if (n_known == 0) begin
      foreach (item_run[i]) begin
        pending_bytes.push_back(item_run[i]);
      end
    end else begin
      for (int i = 0; i < n_known; i++) begin
        fb.octet = known[63 - 8 * i -: 8];
        fb.run_end = (i == n_known - 1);
        fb.frame_end = 1'b0;
        pending_bytes.push_back(fb);
      end
    end
  endtask

  // Frame numbers are spread over every digit count, with the edges of the
  // range and single set bits showing up often.
  function automatic logic [15:0] pick_frame_number();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 9));
      1: return 16'($urandom_range(10, 99));
      2: return 16'($urandom_range(100, 9999));
      3: return 16'($urandom);
      default: begin
        case ($urandom_range(0, 2))
          0: return 16'd0;
          1: return 16'hFFFF;
          default: return 16'(1 << $urandom_range(0, 15));
        endcase
      end
    endcase
  endfunction

  // Message bytes favour the control characters and the extremes now and then.
  function automatic logic [7:0] pick_message_byte();
    if ($urandom_range(0, 99) < 15) begin
      case ($urandom_range(0, 4))
        0: return crc8fb_pkg::ChNul;
        1: return crc8fb_pkg::ChSoh;
        2: return crc8fb_pkg::ChStx;
        3: return crc8fb_pkg::ChEtx;
        default: return 8'hFF;
      endcase
    end
    return 8'($urandom);
  endfunction

  // Output side: every transfer is checked against the oldest owed byte, and
  // the sink holds back at random except during the steady stretch.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_bytes.size() == 0) begin
        $error("out_byte: no byte expected, got %02h", out_byte_o);
        err_count++;
      end else begin
        head_byte = pending_bytes.pop_front();
        if (out_byte_o !== head_byte.octet) begin
          $error("out_byte: expected %02h, got %02h", head_byte.octet, out_byte_o);
          err_count++;
        end
        if (run_end_o !== head_byte.run_end) begin
          $error("run_end: expected %0b, got %0b", head_byte.run_end, run_end_o);
          err_count++;
        end
        if (frame_end_o !== head_byte.frame_end) begin
          $error("frame_end: expected %0b, got %0b", head_byte.frame_end, frame_end_o);
          err_count++;
        end
      end
    end
    out_ready_i <= steady || ($urandom_range(0, 99) >= IdlePercent);
  end

  // Watchdog: a hung handshake or a byte that never arrives ends up here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    int          sent;
    int          frame_len;
    logic [15:0] number;

    sent = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table first; it ends with a closed frame.
    for (int r = 0; r < NumDirRows; r++) begin
      send_message_byte(DirRows[r].number, DirRows[r].data, DirRows[r].last,
                        DirRows[r].n_known, DirRows[r].known);
    end

    // Random well-formed frames. About a third are one-byte frames; most of
    // the rest are short, with the odd long one. The number offered on the
    // bytes after the first is noise that the block must ignore.
    while (sent < RandomItems) begin
      case ($urandom_range(0, 9))
        0, 1, 2: frame_len = 1;
        9:       frame_len = $urandom_range(8, 16);
        default: frame_len = $urandom_range(2, 6);
      endcase
      number = pick_frame_number();
      for (int k = 0; k < frame_len; k++) begin
        steady = (sent >= 80) && (sent < 140);
        send_message_byte((k == 0) ? number : 16'($urandom), pick_message_byte(),
                          k == frame_len - 1, 4'd0, 64'h0);
        sent++;
      end
    end
    steady = 1'b0;
    in_valid_i <= 1'b0;

    while (pending_bytes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### crc8_frame_builder.f
design/crc8fb_pkg.sv
design/crc8fb_front.sv
design/crc8fb_fifo.sv
design/crc8fb_back.sv
design/crc8_frame_builder.sv
dv/tb_crc8_frame_builder.sv
